/* rtl/lcw_decompressor_assert.svh */
// Assertion macros for the LCW decompressor.
// Used by the top level only; no other dependencies.
`ifndef LCW_DECOMPRESSOR_ASSERT_SVH
`define LCW_DECOMPRESSOR_ASSERT_SVH
// Checks that a condition implies a consequence on the same edge.
`define LCW_ASSERT_IMP(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("lcw assertion failed");
// Checks that a condition implies a consequence on the next edge.
`define LCW_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("lcw assertion failed");
`endif

/* rtl/lcw_pkg.sv */
// Shared types and constants for the LCW decompressor.
// No dependencies.
package lcw_pkg;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_FIRST     = 4'd0,
    PH_CMD       = 4'd1,
    PH_OP1       = 4'd2,
    PH_OP2       = 4'd3,
    PH_OP3       = 4'd4,
    PH_OP4       = 4'd5,
    PH_LIT       = 4'd6,
    PH_COPY      = 4'd7,
    PH_FILL      = 4'd8,
    PH_COPY_LAST = 4'd9,
    PH_FILL_LAST = 4'd10
  } phase_t;

  // End reasons on the final item.
  localparam logic [1:0] END_MARKER = 2'd0;
  localparam logic [1:0] END_LIMIT  = 2'd1;
  localparam logic [1:0] END_INPUT  = 2'd2;

  localparam logic [7:0] CMD_END  = 8'h80;
  localparam logic [7:0] CMD_LONG = 8'hff;
  localparam logic [7:0] CMD_FILL = 8'hfe;
  localparam logic [16:0] LIMIT_CAP = 17'd65536;

  // One result item.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_final;
    logic [16:0] total_length;
    logic [1:0]  end_reason;
  } result_t;

endpackage

/* rtl/lcw_hist_ram.sv */
// History memory of the LCW decompressor: one write port and one read port.
// Read data is registered. Depends on nothing.
module lcw_hist_ram #(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/lcw_out_fifo.sv */
// Small result queue of the LCW decompressor, four entries deep.
// Uses lcw_pkg for the result type.
module lcw_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lcw_pkg::result_t din,
  input  logic            pop,
  output lcw_pkg::result_t dout,
  output logic            nonempty,
  output logic [2:0]      level
);

  lcw_pkg::result_t q [4];
  logic [1:0] rp;
  logic [1:0] wp;

  assign dout = q[rp];
  assign nonempty = (level != 3'd0);

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      rp <= 2'd0;
      wp <= 2'd0;
      level <= 3'd0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      level <= level + {2'd0, push} - {2'd0, pop};
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) q[wp] <= din;
  end

endmodule

/* rtl/lcw_decompressor.sv */
// LCW decompressor with parser, history memory and a result queue.
// Uses lcw_pkg, lcw_hist_ram, lcw_out_fifo and lcw_decompressor_assert.svh.
//
// An item is accepted every cycle while the result queue, counting a copy byte
// still in flight, holds no more than two results, so only a stalled result
// channel slows the input. A literal or fill byte enters the result queue at
// the edge that accepts its item. A pulled copy byte is read from the history
// memory, which has a registered read, and waits in the second stage first.
// A copy byte still being written when the next pull reads its address is
// forwarded around the memory, so overlapping copies at distance one keep the
// full rate. A final item made with a byte waits in the hold register and
// enters the queue after that byte. The history memory needs no clearing pass.
module lcw_decompressor #(
  parameter int HISTORY_SIZE = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        is_final,
  output logic [16:0] total_length,
  output logic [1:0]  end_reason,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data
);

  localparam int AW = $clog2(HISTORY_SIZE);

  // Architectural state.
  logic [16:0]     output_limit;
  logic [16:0]     write_index;
  logic            relative_mode;
  lcw_pkg::phase_t parse_phase;
  logic [7:0]      command_code;
  logic [15:0]     pending_count;
  logic [15:0]     copy_position;
  logic [7:0]      fill_value;
  logic            finished;

  logic [16:0]     write_index_next;
  logic            relative_mode_next;
  lcw_pkg::phase_t parse_phase_next;
  logic [7:0]      command_code_next;
  logic [15:0]     pending_count_next;
  logic [15:0]     copy_position_next;
  logic [7:0]      fill_value_next;
  logic            finished_next;

  // Second stage: a copy byte waiting for the memory read.
  logic            s2_valid;
  logic            s2_fwd;
  logic [7:0]      s2_fwd_byte;
  logic            s2_fin;
  logic [1:0]      s2_reason;
  logic [16:0]     s2_len;

  // Queue signals.
  lcw_pkg::result_t q_din [2];
  logic             q_push [2];
  lcw_pkg::result_t f_din;
  logic             f_push;
  lcw_pkg::result_t f_dout;
  logic             f_nonempty;
  logic [2:0]       f_level;
  logic             accept;

  // Memory ports.
  logic          ram_we;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [7:0]    ram_rdata;

  logic [16:0] eff_limit;
  assign eff_limit = (output_limit > lcw_pkg::LIMIT_CAP) ? lcw_pkg::LIMIT_CAP : output_limit;

  // Room: stall unless queue plus the copy byte in flight and its final item leave room for two more results.
  assign in_stall = ({1'b0, f_level} + {3'd0, s2_valid} + {3'd0, s2_fin}) > 4'd2;
  assign accept = in_valid && !in_stall;

  // Parser and producer.
  logic        prod;
  logic [7:0]  prod_byte;
  logic        prod_copy;
  logic        fin;
  logic [1:0]  fin_reason;
  logic [16:0] wi_inc;
  logic [15:0] len_cp;
  logic [16:0] lenw;

  always_comb begin
    write_index_next = write_index;
    relative_mode_next = relative_mode;
    parse_phase_next = parse_phase;
    command_code_next = command_code;
    pending_count_next = pending_count;
    copy_position_next = copy_position;
    fill_value_next = fill_value;
    finished_next = finished;
    prod = 1'b0;
    prod_byte = data_byte;
    prod_copy = 1'b0;
    fin = 1'b0;
    fin_reason = lcw_pkg::END_INPUT;
    wi_inc = write_index + 17'd1;
    len_cp = 16'd0;
    lenw = 17'd0;
    if (accept && !finished) begin
      if (write_index >= eff_limit) begin
        fin = 1'b1;
        fin_reason = lcw_pkg::END_LIMIT;
      end else if (!kind) begin
        unique case (parse_phase)
          lcw_pkg::PH_FIRST, lcw_pkg::PH_CMD: begin
            if (parse_phase == lcw_pkg::PH_FIRST && data_byte == 8'h00) begin
              relative_mode_next = 1'b1;
              parse_phase_next = lcw_pkg::PH_CMD;
              fin = last_byte;
            end else if (data_byte == lcw_pkg::CMD_END) begin
              fin = 1'b1;
              fin_reason = lcw_pkg::END_MARKER;
            end else begin
              command_code_next = data_byte;
              if (data_byte >= 8'h81 && data_byte <= 8'hbf) begin
                pending_count_next = {10'd0, data_byte[5:0]};
                parse_phase_next = lcw_pkg::PH_LIT;
              end else begin
                parse_phase_next = lcw_pkg::PH_OP1;
              end
              fin = last_byte;
            end
          end
          lcw_pkg::PH_OP1, lcw_pkg::PH_OP2, lcw_pkg::PH_OP3, lcw_pkg::PH_OP4: begin
            fin = last_byte;
            lenw = 17'd0;
            if (command_code == lcw_pkg::CMD_LONG || command_code == lcw_pkg::CMD_FILL) begin
              unique case (parse_phase)
                lcw_pkg::PH_OP1: begin
                  pending_count_next = {8'd0, data_byte};
                  parse_phase_next = lcw_pkg::PH_OP2;
                end
                lcw_pkg::PH_OP2: begin
                  pending_count_next = {data_byte, pending_count[7:0]};
                  parse_phase_next = lcw_pkg::PH_OP3;
                end
                lcw_pkg::PH_OP3: begin
                  if (command_code == lcw_pkg::CMD_FILL) begin
                    fill_value_next = data_byte;
                    lenw = {1'b1, pending_count};
                  end else begin
                    copy_position_next = {8'd0, data_byte};
                    parse_phase_next = lcw_pkg::PH_OP4;
                  end
                end
                default: begin
                  copy_position_next = relative_mode ?
                    (write_index[15:0] - {data_byte, copy_position[7:0]}) :
                    {data_byte, copy_position[7:0]};
                  lenw = {1'b1, pending_count};
                end
              endcase
            end else if (command_code >= 8'hc0) begin
              if (parse_phase == lcw_pkg::PH_OP1) begin
                copy_position_next = {8'd0, data_byte};
                parse_phase_next = lcw_pkg::PH_OP2;
              end else begin
                copy_position_next = relative_mode ?
                  (write_index[15:0] - {data_byte, copy_position[7:0]}) :
                  {data_byte, copy_position[7:0]};
                lenw = {1'b1, 10'd0, command_code[5:0]} + 17'd3;
              end
            end else if (command_code < 8'h80) begin
              copy_position_next = write_index[15:0] - {4'd0, command_code[3:0], data_byte};
              lenw = {1'b1, 13'd0, command_code[6:4]} + 17'd3;
            end else begin
              parse_phase_next = lcw_pkg::PH_CMD;
            end
            // Start a pending copy or fill.
            if (lenw[16]) begin
              len_cp = lenw[15:0];
              pending_count_next = len_cp;
              if (len_cp == 16'd0) begin
                parse_phase_next = lcw_pkg::PH_CMD;
              end else begin
                fin = 1'b0;
                if (command_code == lcw_pkg::CMD_FILL)
                  parse_phase_next = last_byte ? lcw_pkg::PH_FILL_LAST : lcw_pkg::PH_FILL;
                else
                  parse_phase_next = last_byte ? lcw_pkg::PH_COPY_LAST : lcw_pkg::PH_COPY;
              end
            end
          end
          lcw_pkg::PH_LIT: begin
            prod = 1'b1;
            pending_count_next = pending_count - 16'd1;
            if (wi_inc >= eff_limit) begin
              fin = 1'b1;
              fin_reason = lcw_pkg::END_LIMIT;
            end else begin
              if (pending_count == 16'd1) parse_phase_next = lcw_pkg::PH_CMD;
              fin = last_byte;
            end
          end
          default: ;
        endcase
      end else if (parse_phase == lcw_pkg::PH_COPY || parse_phase == lcw_pkg::PH_COPY_LAST ||
                   parse_phase == lcw_pkg::PH_FILL || parse_phase == lcw_pkg::PH_FILL_LAST) begin
        prod = 1'b1;
        prod_copy = (parse_phase == lcw_pkg::PH_COPY || parse_phase == lcw_pkg::PH_COPY_LAST);
        prod_byte = fill_value;
        if (prod_copy) copy_position_next = copy_position + 16'd1;
        pending_count_next = pending_count - 16'd1;
        if (wi_inc >= eff_limit) begin
          fin = 1'b1;
          fin_reason = lcw_pkg::END_LIMIT;
        end else if (pending_count == 16'd1) begin
          if (parse_phase == lcw_pkg::PH_COPY_LAST || parse_phase == lcw_pkg::PH_FILL_LAST)
            fin = 1'b1;
          else
            parse_phase_next = lcw_pkg::PH_CMD;
        end
      end
      if (prod) write_index_next = wi_inc;
      if (fin) finished_next = 1'b1;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= lcw_pkg::LIMIT_CAP;
      write_index <= 17'd0;
      relative_mode <= 1'b0;
      parse_phase <= lcw_pkg::PH_FIRST;
      command_code <= 8'd0;
      pending_count <= 16'd0;
      copy_position <= 16'd0;
      fill_value <= 8'd0;
      finished <= 1'b0;
    end else begin
      if (cfg_we) output_limit <= cfg_data;
      write_index <= write_index_next;
      relative_mode <= relative_mode_next;
      parse_phase <= parse_phase_next;
      command_code <= command_code_next;
      pending_count <= pending_count_next;
      copy_position <= copy_position_next;
      fill_value <= fill_value_next;
      finished <= finished_next;
    end
  end

  // Memory write: literals and fills are known now; a copy byte is written
  // when its read data returns, in the next cycle.
  logic [7:0] s2_byte;
  logic [AW-1:0] s2_waddr;
  assign s2_byte = s2_fwd ? s2_fwd_byte : ram_rdata;
  assign ram_we = (prod && !prod_copy) || s2_valid;
  assign ram_wdata = s2_valid ? s2_byte : prod_byte;
  assign ram_re = prod && prod_copy;

  logic [AW-1:0] waddr;
  assign waddr = s2_valid ? s2_waddr : write_index[AW-1:0];

  lcw_hist_ram #(.AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (copy_position[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Forwarding: the byte read may be the one being written this cycle.
  logic       fwd_now;
  logic [7:0] fwd_byte;
  assign fwd_now = ram_we && (waddr == copy_position[AW-1:0]);
  assign fwd_byte = ram_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_fin <= 1'b0;
    end else begin
      s2_valid <= ram_re;
      s2_fin <= ram_re && fin;
    end
  end

  always_ff @(posedge clk) begin
    s2_fwd <= fwd_now;
    s2_fwd_byte <= fwd_byte;
    s2_reason <= fin_reason;
    s2_len <= wi_inc;
    s2_waddr <= write_index[AW-1:0];
  end

  // Results: the copy byte from stage two goes first, then those of now.
  always_comb begin
    q_push[0] = 1'b0;
    q_push[1] = 1'b0;
    q_din[0] = '0;
    q_din[1] = '0;
    if (s2_valid) begin
      q_push[0] = 1'b1;
      q_din[0] = '{s2_byte, 1'b0, s2_len, lcw_pkg::END_MARKER};
      q_push[1] = s2_fin;
      q_din[1] = '{8'd0, 1'b1, s2_len, s2_reason};
    end
    if (!ram_re) begin
      if (prod) begin
        q_push[s2_valid ? 1 : 0] = 1'b1;
        q_din[s2_valid ? 1 : 0] = '{prod_byte, 1'b0, wi_inc, lcw_pkg::END_MARKER};
      end
      if (fin && !prod) begin
        q_push[s2_valid ? 1 : 0] = 1'b1;
        q_din[s2_valid ? 1 : 0] = '{8'd0, 1'b1, write_index, fin_reason};
      end
    end
  end

  // A second staging register lets two results enter the queue one a cycle.
  lcw_pkg::result_t hold;
  logic hold_valid;
  logic prod_fin;
  assign prod_fin = !ram_re && prod && fin;

  always_ff @(posedge clk) begin
    if (rst) hold_valid <= 1'b0;
    else hold_valid <= (q_push[0] && q_push[1]) || prod_fin ||
                       (hold_valid && (q_push[0] || q_push[1]) && 1'b0);
  end

  lcw_pkg::result_t hold_din;
  always_comb begin
    if (prod_fin) hold_din = '{8'd0, 1'b1, wi_inc, fin_reason};
    else hold_din = q_din[1];
  end

  always_ff @(posedge clk) begin
    hold <= hold_din;
  end

  // Queue input: held result first, else the first new one.
  always_comb begin
    f_push = hold_valid || q_push[0];
    f_din = hold_valid ? hold : q_din[0];
  end

  // Extra queue absorbs a first result when the hold register is busy.
  lcw_pkg::result_t g_dout;
  logic g_nonempty;
  logic [2:0] g_level;
  logic g_push;
  assign g_push = hold_valid && q_push[0];

  lcw_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .din      (f_din),
    .pop      (out_valid && !out_stall && !g_nonempty),
    .dout     (f_dout),
    .nonempty (f_nonempty),
    .level    (f_level)
  );

  lcw_out_fifo u_fifo_b (
    .clk      (clk),
    .rst      (rst),
    .push     (g_push),
    .din      (q_din[0]),
    .pop      (out_valid && !out_stall && g_nonempty),
    .dout     (g_dout),
    .nonempty (g_nonempty),
    .level    (g_level)
  );

  assign out_valid = f_nonempty || g_nonempty;
  assign out_byte = g_nonempty ? g_dout.out_byte : f_dout.out_byte;
  assign is_final = g_nonempty ? g_dout.is_final : f_dout.is_final;
  assign total_length = g_nonempty ? g_dout.total_length : f_dout.total_length;
  assign end_reason = g_nonempty ? g_dout.end_reason : f_dout.end_reason;

  `include "lcw_decompressor_assert.svh"

  // After the final item nothing more is produced.
  `LCW_ASSERT_NEXT(a_fin_stays, finished, finished)
  `LCW_ASSERT_IMP(a_no_prod_after_fin, finished, !prod)
  `LCW_ASSERT_IMP(a_read_is_copy, ram_re, prod_copy)
  // Two results in one cycle always end the stream, so the extra queue stays empty.
  `LCW_ASSERT_IMP(a_extra_queue_idle, 1'b1, g_level == 3'd0)

endmodule
